FILE: rtl/tpmc_pkg.sv
// ----------------------------------------------------------------------------
// tpmc_pkg
// Types, codes and constants shared by the tachometer / pwm motor control
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpmc_pkg;

  localparam int DIVIDEND_W = 22;
  localparam int DIVISOR_W  = 10;
  localparam int DIV_CNT_W  = 5;

  localparam int DutyMax = 255;

  localparam logic [2:0] OP_PULSE  = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_CMD    = 3'd2;
  localparam logic [2:0] OP_BUTTON = 3'd3;
  localparam logic [2:0] OP_ADC    = 3'd4;

  localparam logic [7:0] CMD_TOGGLE = 8'h4F;  // 'O'
  localparam logic [7:0] CMD_CLEAR  = 8'h52;  // 'R'
  localparam logic [7:0] CMD_EXT    = 8'h45;  // 'E'
  localparam logic [7:0] CMD_POT    = 8'h50;  // 'P'
  localparam logic [7:0] CMD_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CMD_MINUS  = 8'h2D;  // '-'

  localparam logic [1:0] REG_PULSES_PER_REV   = 2'd0;
  localparam logic [1:0] REG_TICKS_PER_WINDOW = 2'd1;
  localparam logic [1:0] REG_DUTY_STEP        = 2'd2;

  localparam logic [7:0]  RESET_PULSES_PER_REV   = 8'd20;
  localparam logic [3:0]  RESET_TICKS_PER_WINDOW = 4'd4;
  localparam logic [7:0]  RESET_DUTY_STEP        = 8'd10;
  localparam logic [DIVISOR_W-1:0] ADC_FULL      = 10'd1023;

  // adc * 255 / 1023 as adc * scale >> 20, exact over the 10-bit range
  localparam logic [17:0] ADC_DUTY_SCALE = 18'd261376;
  // x / 255 as x * scale >> 23, exact for x up to 25500
  localparam logic [15:0] PCT_SCALE      = 16'd32897;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  command_byte;
    logic        toggle_button;
    logic        clear_button;
    logic [9:0]  adc_sample;
  } in_t;

  typedef struct packed {
    logic [15:0] rpm;
    logic [15:0] revolutions;
    logic [7:0]  duty;
    logic [6:0]  duty_percent;
    logic        motor_on;
    logic        command_mode;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_RPM,
    S_REVS,
    S_HOLD
  } state_t;

  typedef enum logic [1:0] {
    DIV_RPM,
    DIV_REVS
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     apply;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_rpm;
    logic     latch_revs;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_rpm;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [6:0] duty_to_percent(input logic [7:0] d);
    logic [14:0] prod;
    logic [30:0] scaled;
    prod   = 15'(d) * 15'd100;
    scaled = 31'(prod) * 31'(PCT_SCALE);
    return scaled[29:23];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tpmc_div.sv
// ----------------------------------------------------------------------------
// tpmc_div
// Restoring radix-2 divider, one quotient bit per cycle, one-cycle done
// pulse when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmc_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [tpmc_pkg::DIVIDEND_W-1:0]      dividend,
  input  wire logic [tpmc_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                      done,
  output logic [tpmc_pkg::DIVIDEND_W-1:0]           quotient
);

  logic                               busy_r;
  logic                               done_r;
  logic [tpmc_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [tpmc_pkg::DIVIDEND_W-1:0]    quo_r;
  logic [tpmc_pkg::DIVISOR_W-1:0]     rem_r;
  logic [tpmc_pkg::DIVISOR_W-1:0]     dvs_r;

  logic [tpmc_pkg::DIVISOR_W:0]       shifted;
  logic [tpmc_pkg::DIVISOR_W:0]       diff;
  logic                               ge;
  logic [tpmc_pkg::DIVISOR_W-1:0]     rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[tpmc_pkg::DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[tpmc_pkg::DIVISOR_W-1:0] : shifted[tpmc_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= tpmc_pkg::DIV_CNT_W'(tpmc_pkg::DIVIDEND_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[tpmc_pkg::DIVIDEND_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/tpmc_datapath.sv
// ----------------------------------------------------------------------------
// tpmc_datapath
// Configuration and state registers, event update logic, divider operand
// selection and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmc_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_addr,
  input  wire logic [7:0]           cfg_wdata,
  input  wire tpmc_pkg::in_t        in_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output tpmc_pkg::out_t            out_data,
  input  wire tpmc_pkg::ctrl_cmd_t  cmd,
  output tpmc_pkg::ctrl_sts_t       sts
);

  logic [7:0]  ppr_r;
  logic [3:0]  tpw_r;
  logic [7:0]  step_r;

  logic [15:0] pulse_r, pulse_nxt;
  logic [15:0] rev_r, rev_nxt;
  logic [3:0]  tick_r, tick_nxt;
  logic [15:0] rpm_r;
  logic [7:0]  duty_r, duty_nxt;
  logic        motor_r, motor_nxt;
  logic        cmode_r, cmode_nxt;
  logic        prev_tog_r, prev_tog_nxt;
  logic [15:0] revs_q_r;

  tpmc_pkg::in_t  in_r;
  logic           out_valid_r;
  tpmc_pkg::out_t out_r;

  logic [3:0]  tick_inc;
  logic [8:0]  duty_sum;
  logic        window_end;
  logic [27:0] adc_scaled;

  logic                             div_start;
  logic [tpmc_pkg::DIVIDEND_W-1:0]  div_dividend;
  logic [tpmc_pkg::DIVISOR_W-1:0]   div_divisor;
  logic [tpmc_pkg::DIVISOR_W-1:0]   ppr_div;
  logic                             div_done;
  logic [tpmc_pkg::DIVIDEND_W-1:0]  div_quo;

  tpmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r  <= tpmc_pkg::RESET_PULSES_PER_REV;
      tpw_r  <= tpmc_pkg::RESET_TICKS_PER_WINDOW;
      step_r <= tpmc_pkg::RESET_DUTY_STEP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tpmc_pkg::REG_PULSES_PER_REV:   ppr_r  <= cfg_wdata;
        tpmc_pkg::REG_TICKS_PER_WINDOW: tpw_r  <= cfg_wdata[3:0];
        tpmc_pkg::REG_DUTY_STEP:        step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // event update
  always_comb begin
    tick_inc     = tick_r + 4'd1;
    window_end   = tick_inc >= tpw_r;
    duty_sum     = {1'b0, duty_r} + {1'b0, step_r};
    adc_scaled   = 28'(in_r.adc_sample) * 28'(tpmc_pkg::ADC_DUTY_SCALE);
    pulse_nxt    = pulse_r;
    rev_nxt      = rev_r;
    tick_nxt     = tick_r;
    duty_nxt     = duty_r;
    motor_nxt    = motor_r;
    cmode_nxt    = cmode_r;
    prev_tog_nxt = prev_tog_r;
    if (cmd.apply) begin
      unique case (in_r.op)
        tpmc_pkg::OP_PULSE: begin
          pulse_nxt = (pulse_r == 16'hFFFF) ? pulse_r : pulse_r + 16'd1;
          rev_nxt   = (rev_r == 16'hFFFF) ? rev_r : rev_r + 16'd1;
        end
        tpmc_pkg::OP_TICK: begin
          if (window_end) begin
            tick_nxt  = 4'd0;
            pulse_nxt = 16'd0;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        tpmc_pkg::OP_CMD: begin
          unique case (in_r.command_byte)
            tpmc_pkg::CMD_TOGGLE: motor_nxt = !motor_r;
            tpmc_pkg::CMD_CLEAR:  rev_nxt   = 16'd0;
            tpmc_pkg::CMD_EXT:    cmode_nxt = 1'b1;
            tpmc_pkg::CMD_POT:    cmode_nxt = 1'b0;
            tpmc_pkg::CMD_PLUS: begin
              if (cmode_r) begin
                duty_nxt = duty_sum[8] ? 8'hFF : duty_sum[7:0];
              end
            end
            tpmc_pkg::CMD_MINUS: begin
              if (cmode_r) begin
                duty_nxt = (duty_r >= step_r) ? duty_r - step_r : 8'd0;
              end
            end
            default: ;
          endcase
        end
        tpmc_pkg::OP_BUTTON: begin
          if (in_r.toggle_button && !prev_tog_r) begin
            motor_nxt = !motor_r;
          end
          prev_tog_nxt = in_r.toggle_button;
          if (in_r.clear_button) begin
            rev_nxt = 16'd0;
          end
        end
        tpmc_pkg::OP_ADC: begin
          if (!cmode_r) begin
            duty_nxt = adc_scaled[27:20];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r    <= '0;
      rev_r      <= '0;
      tick_r     <= '0;
      rpm_r      <= '0;
      duty_r     <= '0;
      motor_r    <= 1'b0;
      cmode_r    <= 1'b0;
      prev_tog_r <= 1'b0;
    end else begin
      pulse_r    <= pulse_nxt;
      rev_r      <= rev_nxt;
      tick_r     <= tick_nxt;
      duty_r     <= duty_nxt;
      motor_r    <= motor_nxt;
      cmode_r    <= cmode_nxt;
      prev_tog_r <= prev_tog_nxt;
      if (cmd.latch_rpm) begin
        rpm_r <= (div_quo[tpmc_pkg::DIVIDEND_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
      end
    end
  end

  // divider operands
  always_comb begin
    ppr_div   = (ppr_r == 8'd0) ? tpmc_pkg::DIVISOR_W'(1) : tpmc_pkg::DIVISOR_W'(ppr_r);
    div_start = cmd.div_start;
    case (cmd.div_sel)
      tpmc_pkg::DIV_RPM: begin
        div_dividend = (tpmc_pkg::DIVIDEND_W'(pulse_r) << 6)
                     - (tpmc_pkg::DIVIDEND_W'(pulse_r) << 2);
        div_divisor  = ppr_div;
      end
      default: begin
        div_dividend = tpmc_pkg::DIVIDEND_W'(rev_nxt);
        div_divisor  = ppr_div;
      end
    endcase
  end

  // input capture, quotient and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.latch_revs) begin
      revs_q_r <= div_quo[15:0];
    end
    if (cmd.out_load) begin
      out_r.rpm          <= rpm_r;
      out_r.revolutions  <= revs_q_r;
      out_r.duty         <= duty_r;
      out_r.duty_percent <= tpmc_pkg::duty_to_percent(duty_r);
      out_r.motor_on     <= motor_r;
      out_r.command_mode <= cmode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.need_rpm = (in_r.op == tpmc_pkg::OP_TICK) && window_end;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: rtl/tpmc_ctrl.sv
// ----------------------------------------------------------------------------
// tpmc_ctrl
// Controller state machine: takes a transaction, applies it, sequences the
// divisions and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tpmc_pkg::ctrl_sts_t  sts,
  output tpmc_pkg::ctrl_cmd_t       cmd
);

  tpmc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpmc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = tpmc_pkg::DIV_REVS;
    in_stall  = 1'b1;
    unique case (state_r)
      tpmc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = tpmc_pkg::S_APPLY;
        end
      end
      tpmc_pkg::S_APPLY: begin
        cmd.apply     = 1'b1;
        cmd.div_start = 1'b1;
        if (sts.need_rpm) begin
          cmd.div_sel = tpmc_pkg::DIV_RPM;
          state_nxt   = tpmc_pkg::S_RPM;
        end else begin
          state_nxt = tpmc_pkg::S_REVS;
        end
      end
      tpmc_pkg::S_RPM: begin
        if (sts.div_done) begin
          cmd.latch_rpm = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = tpmc_pkg::S_REVS;
        end
      end
      tpmc_pkg::S_REVS: begin
        if (sts.div_done) begin
          cmd.latch_revs = 1'b1;
          state_nxt      = tpmc_pkg::S_HOLD;
        end
      end
      tpmc_pkg::S_HOLD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tpmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = tpmc_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tachometer_pwm_motor_control.sv
// ----------------------------------------------------------------------------
// tachometer_pwm_motor_control
// Pulse / revolution counting, windowed rpm measurement and duty control
// driven by sensor, tick, command, button and adc events.
//
//   channel  ports                          width  direction
//   cfg      cfg_we cfg_addr cfg_wdata      2 / 8  in
//   in       in_valid in_stall in_data      23     in
//   out      out_valid out_stall out_data   49     out
//
// one transaction at a time; when a window closes an rpm division runs
// before the revolution division, each through the shared radix-2
// divider.
// synchronous active-low reset; all counters, duty and flags reset to zero.
// a new transaction is taken while a result waits in the output register;
// out_stall holds only the final hand-off to that register.
// ----------------------------------------------------------------------------
`default_nettype none

module tachometer_pwm_motor_control (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_addr,
  input  wire logic [7:0]      cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire tpmc_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tpmc_pkg::out_t       out_data
);

  tpmc_pkg::ctrl_cmd_t cmd;
  tpmc_pkg::ctrl_sts_t sts;

  tpmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpmc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tpmc_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmc_status_checker
// Watches the register port and both channels of the tachometer / pwm motor
// control block. Every accepted input transaction is run through an
// independent model of the counters, rpm window and duty logic, and the
// resulting status is queued. Every accepted output transaction is compared
// field by field against the oldest queued status.
// ----------------------------------------------------------------------------
module tpmc_status_checker
  import tpmc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire in_t        in_data,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire out_t       out_data,
  output int              error_count,
  output int              pending,
  output int              results_checked
);

  localparam int SecondsPerMinute = 60;
  localparam int RpmMax           = 65535;

  logic [7:0]  pulses_per_rev;
  logic [3:0]  ticks_per_window;
  logic [7:0]  duty_step;

  logic [15:0] pulse_cnt;
  logic [15:0] rev_cnt;
  logic [3:0]  tick_cnt;
  logic [15:0] rpm_val;
  logic [7:0]  duty_val;
  logic        motor_en;
  logic        cmd_mode;
  logic        prev_toggle;

  out_t        expected_status_q[$];
  out_t        oldest;
  int          fails   = 0;
  int          checked = 0;

  function automatic out_t advance_status(input in_t ev);
    out_t s;
    int   div;
    int   quo;
    int   sum;
    // a zero divisor register divides by one
    div = (pulses_per_rev == 8'd0) ? 1 : int'(pulses_per_rev);
    case (ev.op)
      OP_PULSE: begin
        if (pulse_cnt != 16'hFFFF) pulse_cnt = pulse_cnt + 16'd1;
        if (rev_cnt != 16'hFFFF) rev_cnt = rev_cnt + 16'd1;
      end
      OP_TICK: begin
        tick_cnt = tick_cnt + 4'd1;
        if (tick_cnt >= ticks_per_window) begin
          quo       = (int'(pulse_cnt) * SecondsPerMinute) / div;
          rpm_val   = (quo > RpmMax) ? 16'hFFFF : 16'(quo);
          pulse_cnt = '0;
          tick_cnt  = '0;
        end
      end
      OP_CMD: begin
        case (ev.command_byte)
          CMD_TOGGLE: motor_en = !motor_en;
          CMD_CLEAR:  rev_cnt = '0;
          CMD_EXT:    cmd_mode = 1'b1;
          CMD_POT:    cmd_mode = 1'b0;
          CMD_PLUS: begin
            if (cmd_mode) begin
              sum      = int'(duty_val) + int'(duty_step);
              duty_val = (sum > DutyMax) ? 8'hFF : 8'(sum);
            end
          end
          CMD_MINUS: begin
            if (cmd_mode) duty_val = (duty_val >= duty_step) ? duty_val - duty_step : 8'd0;
          end
          default: ;
        endcase
      end
      OP_BUTTON: begin
        if (ev.toggle_button && !prev_toggle) motor_en = !motor_en;
        prev_toggle = ev.toggle_button;
        if (ev.clear_button) rev_cnt = '0;
      end
      OP_ADC: begin
        if (!cmd_mode) duty_val = 8'((int'(ev.adc_sample) * DutyMax) / int'(ADC_FULL));
      end
      default: ;
    endcase
    s.rpm          = rpm_val;
    s.revolutions  = 16'(int'(rev_cnt) / div);
    s.duty         = duty_val;
    s.duty_percent = 7'((int'(duty_val) * 100) / DutyMax);
    s.motor_on     = motor_en;
    s.command_mode = cmd_mode;
    return s;
  endfunction

  task automatic check_field(input string field, input int expv, input int gotv);
    if (expv != gotv) begin
      $error("%s: expected %0d, got %0d", field, expv, gotv);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pulses_per_rev   = RESET_PULSES_PER_REV;
      ticks_per_window = RESET_TICKS_PER_WINDOW;
      duty_step        = RESET_DUTY_STEP;
      pulse_cnt        = '0;
      rev_cnt          = '0;
      tick_cnt         = '0;
      rpm_val          = '0;
      duty_val         = '0;
      motor_en         = 1'b0;
      cmd_mode         = 1'b0;
      prev_toggle      = 1'b0;
      expected_status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PULSES_PER_REV:   pulses_per_rev = cfg_wdata;
          REG_TICKS_PER_WINDOW: ticks_per_window = cfg_wdata[3:0];
          REG_DUTY_STEP:        duty_step = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_status_q.size() == 0) begin
          $error("output transaction with no status expected");
          fails++;
        end else begin
          oldest = expected_status_q.pop_front();
          check_field("rpm", oldest.rpm, out_data.rpm);
          check_field("revolutions", oldest.revolutions, out_data.revolutions);
          check_field("duty", oldest.duty, out_data.duty);
          check_field("duty_percent", oldest.duty_percent, out_data.duty_percent);
          check_field("motor_on", oldest.motor_on, out_data.motor_on);
          check_field("command_mode", oldest.command_mode, out_data.command_mode);
          checked++;
        end
      end
      if (in_valid && !in_stall) expected_status_q.push_back(advance_status(in_data));
    end
    error_count     <= fails;
    pending         <= expected_status_q.size();
    results_checked <= checked;
  end

endmodule

FILE: tb/sv/tb_tachometer_pwm_motor_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tachometer_pwm_motor_control
// Drives sensor pulses, window ticks, command bytes, button samples and adc
// samples into the motor control block under several register settings,
// including zero and full-scale values, with random idle and stall cycles,
// one long output hold-off and a pulse burst with one-tick windows.
// The status checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tachometer_pwm_motor_control;
  import tpmc_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 60;
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 110;
  localparam int BurstPulses  = 100;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [7:0] CMD_UNKNOWN = 8'hFF;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_addr  = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;

  int error_count;
  int pending;
  int results_checked;
  int items_sent    = 0;
  int settings_used = 0;

  logic sender_quiet   = 1'b0;
  logic receiver_quiet = 1'b0;
  logic hold_req       = 1'b0;
  logic hold_done      = 1'b0;

  always #5 clk = ~clk;

  tachometer_pwm_motor_control DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tpmc_status_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .error_count     (error_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !receiver_quiet && ($urandom_range(0, 99) < 8);
      end
    end
  end

  task automatic offer(input in_t ev);
    in_data  <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (!sender_quiet && ($urandom_range(0, 99) < 8)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_event(input logic [2:0] op, input logic [7:0] cmd,
                            input logic tog, input logic clr, input logic [9:0] adc);
    in_t ev;
    ev.op            = op;
    ev.command_byte  = cmd;
    ev.toggle_button = tog;
    ev.clear_button  = clr;
    ev.adc_sample    = adc;
    offer(ev);
  endtask

  function automatic in_t random_event();
    in_t         ev;
    logic [31:0] raw;
    int          sel;
    raw = $urandom;
    ev  = raw[$bits(in_t)-1:0];
    sel = $urandom_range(0, 99);
    if (sel < 35) ev.op = OP_PULSE;
    else if (sel < 55) ev.op = OP_TICK;
    else if (sel < 78) begin
      ev.op = OP_CMD;
      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 5))
          0: ev.command_byte = CMD_TOGGLE;
          1: ev.command_byte = CMD_CLEAR;
          2: ev.command_byte = CMD_EXT;
          3: ev.command_byte = CMD_POT;
          4: ev.command_byte = CMD_PLUS;
          default: ev.command_byte = CMD_MINUS;
        endcase
      end
    end
    else if (sel < 88) ev.op = OP_BUTTON;
    else if (sel < 97) ev.op = OP_ADC;
    else ev.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return ev;
  endfunction

  // wait until every result is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_registers(input logic [7:0] ppr, input logic [7:0] tpw,
                                 input logic [7:0] step);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PULSES_PER_REV;
    cfg_wdata <= ppr;
    @(posedge clk);
    cfg_addr  <= REG_TICKS_PER_WINDOW;
    cfg_wdata <= tpw;
    @(posedge clk);
    cfg_addr  <= REG_DUTY_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    #10_000_000;
    $display("tachometer_pwm_motor_control verification failed");
    $finish;
  end

  initial begin
    logic [7:0] ppr;
    logic [7:0] tpw;
    logic [7:0] step;
    in_t        ev;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    settings_used = 1;
    send_event(OP_ADC, 8'h00, 1'b0, 1'b0, 10'd1023);
    send_event(OP_ADC, 8'h00, 1'b0, 1'b0, 10'd0);
    send_event(OP_ADC, 8'h00, 1'b0, 1'b0, 10'd512);
    repeat (3) send_event(OP_PULSE, 8'h00, 1'b0, 1'b0, 10'd0);
    repeat (4) send_event(OP_TICK, 8'h00, 1'b0, 1'b0, 10'd0);
    send_event(OP_CMD, CMD_PLUS, 1'b0, 1'b0, 10'd0);
    send_event(OP_CMD, CMD_EXT, 1'b0, 1'b0, 10'd0);
    send_event(OP_ADC, 8'h00, 1'b0, 1'b0, 10'd1023);
    send_event(OP_CMD, CMD_PLUS, 1'b0, 1'b0, 10'd0);
    send_event(OP_CMD, CMD_MINUS, 1'b0, 1'b0, 10'd0);
    send_event(OP_CMD, CMD_TOGGLE, 1'b0, 1'b0, 10'd0);
    send_event(OP_CMD, CMD_CLEAR, 1'b0, 1'b0, 10'd0);
    send_event(OP_CMD, CMD_UNKNOWN, 1'b1, 1'b1, 10'd1023);
    send_event(OP_CMD, CMD_POT, 1'b0, 1'b0, 10'd0);
    send_event(OP_BUTTON, 8'h00, 1'b1, 1'b0, 10'd0);
    send_event(OP_BUTTON, 8'h00, 1'b1, 1'b1, 10'd0);
    send_event(OP_BUTTON, 8'h00, 1'b0, 1'b0, 10'd0);
    send_event(OP_SPARE_LO, 8'hFF, 1'b1, 1'b1, 10'd1023);
    send_event(OP_SPARE_HI, 8'hFF, 1'b1, 1'b1, 10'd1023);
    send_event(OP_CMD, CMD_TOGGLE, 1'b0, 1'b0, 10'd0);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin
          ppr = 8'd0; tpw = 8'd0; step = 8'd0;
        end
        1: begin
          ppr = 8'd1; tpw = 8'h0F; step = 8'd255;
        end
        2: begin
          ppr = 8'd255; tpw = 8'd1; step = 8'd1;
        end
        default: begin
          ppr  = 8'($urandom_range(0, 255));
          tpw  = 8'($urandom_range(0, 255));
          step = 8'($urandom_range(0, 255));
        end
      endcase
      write_registers(ppr, tpw, step);
      sender_quiet   = (p == 2);
      receiver_quiet = (p == 2);
      if (p == 4) hold_req = 1'b1;
      repeat (PhaseItems) offer(random_event());
      drain();
    end

    // pulse burst with one pulse per revolution and one-tick windows
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    write_registers(8'd1, 8'd1, RESET_DUTY_STEP);
    repeat (BurstPulses) begin
      ev    = random_event();
      ev.op = OP_PULSE;
      offer(ev);
    end
    send_event(OP_TICK, 8'h00, 1'b0, 1'b0, 10'd0);
    send_event(OP_BUTTON, 8'h00, 1'b0, 1'b1, 10'd0);
    send_event(OP_TICK, 8'h00, 1'b0, 1'b0, 10'd0);
    drain();

    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("sent %0d input transactions under %0d register settings, compared %0d results",
             items_sent, settings_used, results_checked);
    $display("zero and full-scale registers, a pulse burst and a %0d-cycle hold-off covered",
             HoldCycles);
    if (error_count == 0 && pending == 0) begin
      $display("tachometer_pwm_motor_control verification clean");
    end else begin
      $display("tachometer_pwm_motor_control verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tpmc_pkg.sv
rtl/tpmc_div.sv
rtl/tpmc_datapath.sv
rtl/tpmc_ctrl.sv
rtl/tachometer_pwm_motor_control.sv
tb/sv/tpmc_status_checker.sv
tb/sv/tb_tachometer_pwm_motor_control.sv
